// File: rtl/snx_pkg.sv
// snx_pkg: shared types, constants and arithmetic helpers for the 3d simplex noise pipeline
// no dependencies; used by snx_skew, snx_vertex, simplex_noise_3d and snx_check
`default_nettype none
package snx_pkg;

	localparam int CoordFrac = 16;
	localparam int OutFrac   = 20;
	localparam int WorkFrac  = 28;
	localparam int OutShift  = 2 * WorkFrac - 3 - OutFrac;
	localparam int Div3Shift = 26;
	localparam int Div5Shift = 33;

	typedef logic signed [31:0] coord_t;
	typedef logic signed [23:0] ofs_t;
	typedef logic [7:0]         hidx_t;
	typedef logic signed [31:0] dval_t;
	typedef logic signed [33:0] msum_t;
	typedef logic [27:0]        tval_t;
	typedef logic signed [62:0] term_t;
	typedef logic signed [23:0] noise_t;

	typedef struct packed {
		logic signed [23:0] quo;
		logic [1:0]         rem;
	} div3_t;

	typedef logic [7:0] gtab_t [8];
	localparam gtab_t GradTable = '{8'h15, 8'h38, 8'h32, 8'h2c, 8'h0d, 8'h13, 8'h07, 8'h2a};

	localparam logic [24:0] Div3Bias  = 25'd25165824;
	localparam logic [24:0] Div3Recip = 25'd22369622;
	localparam logic [30:0] Div5Recip = 31'd1717986919;
	localparam logic [63:0] RadLimit  = 64'h0300_0000_0000_0000;
	localparam logic [10:0] ThirdOne  = 11'd682;
	localparam logic [10:0] ThirdTwo  = 11'd1365;
	localparam logic signed [31:0] NoiseMax = 32'sd8388607;
	localparam logic signed [31:0] NoiseMin = -32'sd8388608;

	// floor division by three via biased reciprocal multiply
	function automatic div3_t floor_div3(input logic signed [23:0] x);
		logic [24:0] u;
		logic [49:0] prod;
		logic [23:0] q;
		div3_t res;
		u = 25'(x) + Div3Bias;
		prod = 50'(u) * 50'(Div3Recip);
		q = prod[Div3Shift +: 24];
		res.rem = 2'(u - 25'(q) * 25'd3);
		res.quo = q - 24'h800000;
		return res;
	endfunction

	// bit-sliced table hash, only the low six bits matter
	function automatic logic [5:0] corner_hash(input hidx_t i, input hidx_t j, input hidx_t k);
		logic [5:0] acc;
		logic [2:0] idx;
		logic [1:0] rot;
		acc = '0;
		rot = '0;
		for (int b = 0; b < 8; b++) begin
			if (rot == 2'd0) begin
				idx = {i[b], j[b], k[b]};
			end else if (rot == 2'd1) begin
				idx = {j[b], k[b], i[b]};
			end else begin
				idx = {k[b], i[b], j[b]};
			end
			acc = acc + GradTable[idx][5:0];
			rot = (rot == 2'd2) ? 2'd0 : rot + 2'd1;
		end
		return acc;
	endfunction

	// signed gradient sum picked by the hash
	function automatic msum_t grad_sum(input dval_t d0, input dval_t d1, input dval_t d2,
			input logic [5:0] h);
		msum_t x, y, z, p, q, r;
		logic [1:0] sel;
		x = 34'(d0);
		y = 34'(d1);
		z = 34'(d2);
		sel = h[1:0];
		if (sel == 2'd1) begin
			p = x; q = y; r = z;
		end else if (sel == 2'd2) begin
			p = y; q = z; r = x;
		end else begin
			p = z; q = x; r = y;
		end
		if (h[5] == h[3]) p = -p;
		if (h[5] == h[4]) q = -q;
		if (h[5] != (h[4] ^ h[3])) r = -r;
		if (sel == 2'd0) begin
			return p + q + r;
		end else if (!h[2]) begin
			return p + q;
		end
		return p + r;
	endfunction

endpackage
`default_nettype wire

// File: rtl/simplex_noise_3d.sv
// simplex_noise_3d: fully pipelined 3d simplex noise, one point per clock
// pipeline: 15 register stages (skew 3, rank 1, vertex datapath 9, sum 1, output 1) from start to done
// throughput: one transaction per cycle, busy stays low; reset: arst_n clears all valid bits
// depends on snx_pkg, snx_skew, snx_vertex
`default_nettype none
module simplex_noise_3d (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  snx_pkg::coord_t  coord_x,
	input  snx_pkg::coord_t  coord_y,
	input  snx_pkg::coord_t  coord_z,
	output logic             done,
	output snx_pkg::noise_t  noise_value
);

	logic            skew_vld;
	snx_pkg::ofs_t   v [3];
	snx_pkg::hidx_t  lat [3];

	logic            vld_s4;
	snx_pkg::ofs_t   off_s4 [4][3];
	snx_pkg::hidx_t  hc_s4 [4][3];

	logic            vtx_vld [4];
	snx_pkg::term_t  vtx_term [4];

	logic               vld_s5, done_q;
	logic signed [64:0] sum_s5;
	snx_pkg::noise_t    noise_q;

	logic [1:0]         hi, lo;
	logic signed [2:0]  mid;
	logic [1:0]         st [4][3];
	logic [3:0]         ss [4];
	snx_pkg::ofs_t      off_c [4][3];
	snx_pkg::hidx_t     hc_c [4][3];
	logic signed [64:0] acc;
	logic signed [31:0] shv;
	snx_pkg::noise_t    sat;

	assign busy = 1'b0;

	snx_skew u_skew (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (start),
		.cx        (coord_x),
		.cy        (coord_y),
		.cz        (coord_z),
		.out_valid (skew_vld),
		.v         (v),
		.lat       (lat)
	);

	// vertex ordering by ranking the offsets
	always_comb begin
		hi = (v[0] >= v[2]) ? ((v[0] >= v[1]) ? 2'd0 : 2'd1) : ((v[1] >= v[2]) ? 2'd1 : 2'd2);
		lo = (v[0] <  v[2]) ? ((v[0] <  v[1]) ? 2'd0 : 2'd1) : ((v[1] <  v[2]) ? 2'd1 : 2'd2);
		mid = 3'sd3 - $signed({1'b0, hi}) - $signed({1'b0, lo});
		for (int n = 0; n < 3; n++) begin
			st[0][n] = 2'd0;
			st[1][n] = st[0][n] + 2'(hi == 2'(n));
			st[2][n] = st[1][n] + 2'(mid == 3'(n));
			st[3][n] = st[2][n] + 2'(lo == 2'(n));
		end
		for (int s = 0; s < 4; s++) begin
			ss[s] = 4'(st[s][0]) + 4'(st[s][1]) + 4'(st[s][2]);
			for (int n = 0; n < 3; n++) begin
				off_c[s][n] = v[n]
					- ((24'(st[s][n]) * 24'd6) << snx_pkg::CoordFrac)
					+ (24'(ss[s]) << snx_pkg::CoordFrac);
				hc_c[s][n] = lat[n] + 8'(st[s][n]);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			done_q <= 1'b0;
		end else begin
			vld_s4 <= skew_vld;
			vld_s5 <= vtx_vld[0] & vtx_vld[1] & vtx_vld[2] & vtx_vld[3];
			done_q <= vld_s5;
		end
	end

	always_ff @(posedge clk) begin
		for (int s = 0; s < 4; s++) begin
			for (int n = 0; n < 3; n++) begin
				off_s4[s][n] <= off_c[s][n];
				hc_s4[s][n]  <= hc_c[s][n];
			end
		end
	end

	for (genvar g = 0; g < 4; g++) begin : g_vtx
		snx_vertex u_vertex (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (vld_s4),
			.off       (off_s4[g]),
			.hc        (hc_s4[g]),
			.out_valid (vtx_vld[g]),
			.term      (vtx_term[g])
		);
	end

	always_comb begin
		acc = 65'(vtx_term[0]) + 65'(vtx_term[1]) + 65'(vtx_term[2]) + 65'(vtx_term[3]);
		shv = 32'(sum_s5 >>> snx_pkg::OutShift);
		if (shv > snx_pkg::NoiseMax) begin
			sat = 24'(snx_pkg::NoiseMax);
		end else if (shv < snx_pkg::NoiseMin) begin
			sat = 24'(snx_pkg::NoiseMin);
		end else begin
			sat = 24'(shv);
		end
	end

	always_ff @(posedge clk) begin
		sum_s5 <= acc;
		if (vld_s5) begin
			noise_q <= sat;
		end
	end

	assign done        = done_q;
	assign noise_value = noise_q;

endmodule
`default_nettype wire

// File: rtl/snx_skew.sv
// snx_skew: three-stage skew, cell floor and unskewed cell offset
// depends on snx_pkg
`default_nettype none
module snx_skew (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  snx_pkg::coord_t  cx,
	input  snx_pkg::coord_t  cy,
	input  snx_pkg::coord_t  cz,
	output logic             out_valid,
	output snx_pkg::ofs_t    v [3],
	output snx_pkg::hidx_t   lat [3]
);

	logic                 vld_s1, vld_s2, vld_s3;
	logic signed [23:0]   m_s1 [3];
	logic [23:0]          c_s1 [3];
	logic [23:0]          c_s2 [3];
	snx_pkg::hidx_t       cell_s2 [3];
	snx_pkg::ofs_t        v_s3 [3];
	snx_pkg::hidx_t       cell_s3 [3];

	logic signed [35:0]   sum;
	logic signed [35:0]   num [3];
	logic signed [19:0]   num_hi [3];
	snx_pkg::div3_t       dq [3];
	snx_pkg::hidx_t       csum;
	logic [23:0]          vx [3];

	always_comb begin
		sum = 36'(cx) + 36'(cy) + 36'(cz);
		num[0] = 36'(cx) * 36'sd3 + sum;
		num[1] = 36'(cy) * 36'sd3 + sum;
		num[2] = 36'(cz) * 36'sd3 + sum;
		for (int n = 0; n < 3; n++) begin
			num_hi[n] = $signed(num[n][35:16]);
			dq[n] = snx_pkg::floor_div3(m_s1[n]);
		end
		csum = cell_s2[0] + cell_s2[1] + cell_s2[2];
		for (int n = 0; n < 3; n++) begin
			vx[n] = c_s2[n] * 24'd6
				- ((24'(cell_s2[n]) * 24'd6) << snx_pkg::CoordFrac)
				+ (24'(csum) << snx_pkg::CoordFrac);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		c_s1[0] <= cx[23:0];
		c_s1[1] <= cy[23:0];
		c_s1[2] <= cz[23:0];
		for (int n = 0; n < 3; n++) begin
			m_s1[n]    <= 24'(num_hi[n]);
			c_s2[n]    <= c_s1[n];
			cell_s2[n] <= dq[n].quo[7:0];
			v_s3[n]    <= vx[n];
			cell_s3[n] <= cell_s2[n];
		end
	end

	assign out_valid = vld_s3;
	assign v   = v_s3;
	assign lat = cell_s3;

endmodule
`default_nettype wire

// File: rtl/snx_vertex.sv
// snx_vertex: nine-stage contribution of one simplex vertex
// depends on snx_pkg
`default_nettype none
module snx_vertex (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  snx_pkg::ofs_t    off [3],
	input  snx_pkg::hidx_t   hc [3],
	output logic             out_valid,
	output snx_pkg::term_t   term
);

	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7, vld_s8, vld_s9;

	snx_pkg::dval_t  d_s1 [3];
	logic [5:0]      h_s1;
	logic [59:0]     sq_s2 [3];
	logic [61:0]     r2_s3;
	logic [63:0]     r5_s4;
	logic [29:0]     w_s5;
	snx_pkg::tval_t  t_s6, t2_s7, t4_s8;
	snx_pkg::msum_t  m_s2, m_s3, m_s4, m_s5, m_s6, m_s7, m_s8;
	snx_pkg::term_t  term_s9;

	snx_pkg::div3_t  dq [3];
	snx_pkg::dval_t  dn [3];
	logic [10:0]     fr [3];
	logic signed [63:0] sqp [3];
	logic [63:0]     rem5;
	logic [60:0]     tp;
	logic [55:0]     t2p, t4p;

	always_comb begin
		for (int n = 0; n < 3; n++) begin
			dq[n] = snx_pkg::floor_div3(off[n]);
			if (dq[n].rem == 2'd1) begin
				fr[n] = snx_pkg::ThirdOne;
			end else if (dq[n].rem == 2'd2) begin
				fr[n] = snx_pkg::ThirdTwo;
			end else begin
				fr[n] = '0;
			end
			dn[n] = $signed({dq[n].quo[20:0], 11'd0}) + $signed({21'd0, fr[n]});
			sqp[n] = 64'(d_s1[n]) * 64'(d_s1[n]);
		end
		rem5 = snx_pkg::RadLimit - r5_s4;
		tp   = 61'(w_s5) * 61'(snx_pkg::Div5Recip);
		t2p  = 56'(t_s6) * 56'(t_s6);
		t4p  = 56'(t2_s7) * 56'(t2_s7);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0; vld_s2 <= 1'b0; vld_s3 <= 1'b0;
			vld_s4 <= 1'b0; vld_s5 <= 1'b0; vld_s6 <= 1'b0;
			vld_s7 <= 1'b0; vld_s8 <= 1'b0; vld_s9 <= 1'b0;
		end else begin
			vld_s1 <= in_valid; vld_s2 <= vld_s1; vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;   vld_s5 <= vld_s4; vld_s6 <= vld_s5;
			vld_s7 <= vld_s6;   vld_s8 <= vld_s7; vld_s9 <= vld_s8;
		end
	end

	always_ff @(posedge clk) begin
		for (int n = 0; n < 3; n++) begin
			d_s1[n]  <= dn[n];
			sq_s2[n] <= sqp[n][59:0];
		end
		h_s1  <= snx_pkg::corner_hash(hc[0], hc[1], hc[2]);
		m_s2  <= snx_pkg::grad_sum(d_s1[0], d_s1[1], d_s1[2], h_s1);
		r2_s3 <= 62'(sq_s2[0]) + 62'(sq_s2[1]) + 62'(sq_s2[2]);
		m_s3  <= m_s2;
		r5_s4 <= 64'(r2_s3) + (64'(r2_s3) << 2);
		m_s4  <= m_s3;
		// outside the kernel radius the weight is zero
		if (r5_s4 <= snx_pkg::RadLimit) begin
			w_s5 <= rem5[snx_pkg::WorkFrac +: 30];
		end else begin
			w_s5 <= '0;
		end
		m_s5  <= m_s4;
		t_s6  <= tp[snx_pkg::Div5Shift +: 28];
		m_s6  <= m_s5;
		t2_s7 <= t2p[snx_pkg::WorkFrac +: 28];
		m_s7  <= m_s6;
		t4_s8 <= t4p[snx_pkg::WorkFrac +: 28];
		m_s8  <= m_s7;
		term_s9 <= 63'($signed({1'b0, t4_s8})) * 63'(m_s8);
	end

	assign out_valid = vld_s9;
	assign term = term_s9;

endmodule
`default_nettype wire

// File: rtl/snx_check.sv
// snx_check: port-level checks of latency and determinism for simplex_noise_3d
// depends on snx_pkg; bound to simplex_noise_3d below
`default_nettype none
module snx_check (
	input logic             clk,
	input logic             arst_n,
	input logic             start,
	input logic             busy,
	input snx_pkg::coord_t  coord_x,
	input snx_pkg::coord_t  coord_y,
	input snx_pkg::coord_t  coord_z,
	input logic             done,
	input snx_pkg::noise_t  noise_value
);

	localparam int Latency = 15;

	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##Latency done)
		else $error("transaction produced no result at the expected latency");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, Latency))
		else $error("result without a matching transaction");

	a_deterministic: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && $past(start && !busy) && $stable(coord_x)
			&& $stable(coord_y) && $stable(coord_z))
		|-> ##Latency $stable(noise_value))
		else $error("equal points gave different noise values");

endmodule

bind simplex_noise_3d snx_check u_snx_check (.*);
`default_nettype wire
